// ===== rtl/lkv_pkg.sv =====
// package for the lru key/value store
// types, widths and codes shared by the interfaces and the module; no dependencies
package lkv_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int FUNC_W = 2;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_LOOKUP_MRU = 2'd1,
        FN_INSERT = 2'd2,
        FN_DELETE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FRONT,
        ST_OUT
    } t_state;
endpackage

// ===== rtl/lkv_if.sv =====
// valid/ready channel interfaces for the lru key/value store
// depends on lkv_pkg
interface lkv_req_if;
    logic valid;
    logic ready;
    logic [lkv_pkg::FUNC_W-1:0] func;
    logic signed [lkv_pkg::KEY_W-1:0] key;
    logic signed [lkv_pkg::VAL_W-1:0] new_value;
    modport source(output valid, func, key, new_value, input ready);
    modport sink(input valid, func, key, new_value, output ready);
endinterface

interface lkv_rsp_if;
    logic valid;
    logic ready;
    logic hit;
    logic signed [lkv_pkg::VAL_W-1:0] value;
    modport source(output valid, hit, value, input ready);
    modport sink(input valid, hit, value, output ready);
endinterface

// ===== rtl/lru_key_value_store_unit.sv =====
// lru key/value store, top level: sequencer and the recency-ordered entry memory
// depends on lkv_pkg and lkv_if
//
// usage: one request beat (func, key, new_value) on i_req gives exactly one
// response beat (hit, value) on o_rsp. requests are handled one at a time and
// i_req.ready is high only while the block is idle.
// entries are kept as {key, value} pairs in one memory, ordered by recency with
// position 0 the most recent, so no slot numbers or free list are needed.
// a request reads positions from the front one a cycle (the memory read is
// registered) until the key matches or the n occupied positions are
// exhausted. a refresh or an insert then moves the entries in front of the gap
// back by one position, one read and one write a cycle, and then writes the
// pair at position 0; a delete moves the entries behind the hit forward by one.
// the longest requests are a refresh of the oldest entry and an insert into a
// full store. after the response beat the block returns to idle before it
// takes the next request.
// reset clears the occupied count; the block is ready for a request as soon
// as reset is released. when the receiver stalls, the response is held and the
// next request waits.
module lru_key_value_store_unit #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lkv_req_if.sink   i_req,
    lkv_rsp_if.source o_rsp
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = lkv_pkg::KEY_W + lkv_pkg::VAL_W;

    // {key, value} by recency position
    logic [EW-1:0] ent_mem [ENTRIES];
    logic [EW-1:0] ent_rd, ent_wd;
    logic [AW-1:0] ent_ra, ent_wa;
    logic ent_we;

    lkv_pkg::t_state r_state, n_state;
    lkv_pkg::t_func r_func, n_func;
    logic [CW-1:0] r_used, n_used;
    logic [CW-1:0] r_pos, n_pos;        // next scan read position
    logic r_rdv, n_rdv;                 // ent_rd holds a requested read
    logic [lkv_pkg::KEY_W-1:0] r_key, n_key;
    logic [lkv_pkg::VAL_W-1:0] r_nval, n_nval;
    logic [EW-1:0] r_item, n_item;      // pair written at the front
    logic r_hit, n_hit;
    logic [lkv_pkg::VAL_W-1:0] r_val, n_val;
    logic r_dir, n_dir;                 // 0 moves entries back, 1 moves them forward
    logic [AW-1:0] r_ra, n_ra;
    logic [AW-1:0] r_wa, n_wa;
    logic [CW-1:0] r_nrd, n_nrd;        // reads left in the move

    logic [lkv_pkg::KEY_W-1:0] rd_key;
    logic [lkv_pkg::VAL_W-1:0] rd_val;
    logic s_hit, s_miss, s_full;
    logic [CW-1:0] s_hp, s_moves, s_tail;

    always_ff @(posedge i_clk) begin
        ent_rd <= ent_mem[ent_ra];
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
    end

    assign rd_key = ent_rd[EW-1:lkv_pkg::VAL_W];
    assign rd_val = ent_rd[lkv_pkg::VAL_W-1:0];

    // ent_rd belongs to position r_pos-1 while scanning
    assign s_hit = r_rdv && (rd_key == r_key);
    assign s_miss = (r_pos >= r_used) && !s_hit;
    assign s_hp = r_pos - CW'(1);
    assign s_full = (r_used == CW'(ENTRIES));
    assign s_moves = s_full ? CW'(ENTRIES - 1) : r_used;
    assign s_tail = r_used - r_pos;

    assign i_req.ready = (r_state == lkv_pkg::ST_IDLE);
    assign o_rsp.valid = (r_state == lkv_pkg::ST_OUT);
    assign o_rsp.hit = r_hit;
    assign o_rsp.value = r_val;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (i_req.valid) n_state = lkv_pkg::ST_SCAN;
            end
            lkv_pkg::ST_SCAN: begin
                if (s_hit) begin
                    case (r_func)
                        lkv_pkg::FN_LOOKUP_MRU, lkv_pkg::FN_INSERT: begin
                            n_state = (s_hp == '0) ? lkv_pkg::ST_FRONT : lkv_pkg::ST_SHIFT;
                        end
                        lkv_pkg::FN_DELETE: begin
                            n_state = (s_tail == '0) ? lkv_pkg::ST_OUT : lkv_pkg::ST_SHIFT;
                        end
                        default: n_state = lkv_pkg::ST_OUT;
                    endcase
                end else if (s_miss) begin
                    if (r_func == lkv_pkg::FN_INSERT)
                        n_state = (s_moves == '0) ? lkv_pkg::ST_FRONT : lkv_pkg::ST_SHIFT;
                    else
                        n_state = lkv_pkg::ST_OUT;
                end
            end
            lkv_pkg::ST_SHIFT: begin
                if (r_nrd == '0) n_state = r_dir ? lkv_pkg::ST_OUT : lkv_pkg::ST_FRONT;
            end
            lkv_pkg::ST_FRONT: n_state = lkv_pkg::ST_OUT;
            lkv_pkg::ST_OUT: begin
                if (o_rsp.ready) n_state = lkv_pkg::ST_IDLE;
            end
            default: n_state = lkv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_func = r_func; n_used = r_used; n_pos = r_pos; n_rdv = 1'b0;
        n_key = r_key; n_nval = r_nval; n_item = r_item; n_hit = r_hit;
        n_val = r_val; n_dir = r_dir; n_ra = r_ra; n_wa = r_wa; n_nrd = r_nrd;
        ent_ra = r_pos[AW-1:0];
        ent_we = 1'b0;
        ent_wa = r_wa;
        ent_wd = ent_rd;
        case (r_state)
            lkv_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_func = lkv_pkg::t_func'(i_req.func);
                    n_key = i_req.key;
                    n_nval = i_req.new_value;
                    n_pos = '0; n_hit = 1'b0; n_val = '0;
                end
            end
            lkv_pkg::ST_SCAN: begin
                if (r_pos < r_used) begin
                    n_rdv = 1'b1;
                    n_pos = r_pos + CW'(1);
                end
                if (s_hit) begin
                    n_rdv = 1'b0;
                    n_hit = 1'b1;
                    n_val = rd_val;
                    n_item = {r_key, rd_val};
                    case (r_func)
                        lkv_pkg::FN_LOOKUP_MRU, lkv_pkg::FN_INSERT: begin
                            n_dir = 1'b0;
                            n_ra = AW'(s_hp - CW'(1));
                            n_nrd = s_hp;
                        end
                        lkv_pkg::FN_DELETE: begin
                            n_dir = 1'b1;
                            n_ra = AW'(r_pos);
                            n_nrd = s_tail;
                            n_used = r_used - CW'(1);
                        end
                        default: ;
                    endcase
                end else if (s_miss) begin
                    n_rdv = 1'b0;
                    if (r_func == lkv_pkg::FN_INSERT) begin
                        // a full store drops its last position
                        n_val = r_nval;
                        n_item = {r_key, r_nval};
                        n_dir = 1'b0;
                        n_ra = AW'(s_moves - CW'(1));
                        n_nrd = s_moves;
                        if (!s_full) n_used = r_used + CW'(1);
                    end
                end
            end
            lkv_pkg::ST_SHIFT: begin
                ent_ra = r_ra;
                ent_we = r_rdv;
                if (r_nrd != '0) begin
                    n_rdv = 1'b1;
                    n_nrd = r_nrd - CW'(1);
                    n_wa = r_dir ? r_ra - AW'(1) : r_ra + AW'(1);
                    n_ra = r_dir ? r_ra + AW'(1) : r_ra - AW'(1);
                end
            end
            lkv_pkg::ST_FRONT: begin
                ent_we = 1'b1;
                ent_wa = '0;
                ent_wd = r_item;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkv_pkg::ST_IDLE;
            r_func <= lkv_pkg::FN_LOOKUP;
            r_used <= '0;
            r_pos <= '0;
            r_rdv <= 1'b0;
            r_key <= '0;
            r_nval <= '0;
            r_item <= '0;
            r_hit <= 1'b0;
            r_val <= '0;
            r_dir <= 1'b0;
            r_ra <= '0;
            r_wa <= '0;
            r_nrd <= '0;
        end else begin
            r_state <= n_state;
            r_func <= n_func;
            r_used <= n_used;
            r_pos <= n_pos;
            r_rdv <= n_rdv;
            r_key <= n_key;
            r_nval <= n_nval;
            r_item <= n_item;
            r_hit <= n_hit;
            r_val <= n_val;
            r_dir <= n_dir;
            r_ra <= n_ra;
            r_wa <= n_wa;
            r_nrd <= n_nrd;
        end
    end
endmodule
